// ----- src/ctd_pkg.sv -----
// shared types and constants for the palette texture decoder
// no dependencies; imported by every module of the block
`default_nettype none

package ctd_pkg;

   // palette store geometry
   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_ADDR_W    = 8;
   localparam int COLOR_W       = 16;

   // output coordinate widths and image size caps
   localparam int X_W           = 10;
   localparam int Y_W           = 9;
   localparam int MAX_WIDTH_PX  = 1024;
   localparam int MAX_HEIGHT    = 512;
   localparam int PX_SPAN_W     = 11;
   localparam int WIDTH_CMP_W   = 12;
   localparam int HEIGHT_CMP_W  = 11;

   // front-to-back queue
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOUR_BIT_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_HALFWORDS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_ROWS     = 2'd2;
   localparam int CSR_DATA_W = 10;

   localparam logic [8:0] WIDTH_HALFWORDS_RESET = 9'd256;
   localparam logic [9:0] HEIGHT_ROWS_RESET     = 10'd512;

   typedef enum logic {
      OP_PALETTE_LOAD = 1'b0,
      OP_PIXEL        = 1'b1
   } op_type;

   typedef struct packed {
      logic                  func;
      logic [PAL_ADDR_W-1:0] palette_index;
      logic [COLOR_W-1:0]    palette_color;
      logic [7:0]            pixel_byte;
   } req_type;

   typedef struct packed {
      logic [X_W-1:0] pixel_x;
      logic [Y_W-1:0] pixel_y;
      logic [7:0]     red;
      logic [7:0]     green;
      logic [7:0]     blue;
      logic [7:0]     alpha;
      logic           last_of_run;
      logic           image_end;
   } rsp_type;

   // classified item as it sits in the queue; addr is the palette slot
   // for a load and the raw texture byte for a pixel item
   typedef struct packed {
      op_type                op;
      logic [PAL_ADDR_W-1:0] addr;
      logic [COLOR_W-1:0]    color;
   } entry_type;

   typedef struct packed {
      logic       four_bit_mode;
      logic [8:0] width_halfwords;
      logic [9:0] height_rows;
      logic       restart;
   } cfg_type;

endpackage

`default_nettype wire

// ----- src/ctd_front.sv -----
// input stage: takes request transfers and classifies them into queue entries
// depends on ctd_pkg
`default_nettype none

module ctd_front
   import ctd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  wire req_type   req_data,
   output logic           q_push,
   output entry_type      q_entry,
   input  wire logic      q_full
);

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;
   logic      accept;

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && !q_full;
   assign q_entry   = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   // pixel items carry the texture byte in the address slot
   always_comb begin
      entry_in.op    = op_type'(req_data.func);
      entry_in.color = req_data.palette_color;
      if (op_type'(req_data.func) == OP_PIXEL) begin
         entry_in.addr = req_data.pixel_byte;
      end else begin
         entry_in.addr = req_data.palette_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ctd_queue.sv -----
// short fifo between the front and back parts of the decoder
// depends on ctd_pkg
`default_nettype none

module ctd_queue
   import ctd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   entry_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- src/ctd_back.sv -----
// back part: palette store, tile walk and pixel output register
// depends on ctd_pkg; fed by ctd_queue
`default_nettype none

module ctd_back
   import ctd_pkg::*;
#(
   parameter int TILE_WIDTH_PIXELS = 128,
   parameter int TILE_HEIGHT_ROWS  = 32
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire entry_type q_entry,
   output logic           q_pop,
   output logic           rsp_valid,
   output rsp_type        rsp_data,
   input  wire logic      rsp_stall
);

   localparam int CIT_W = $clog2(TILE_WIDTH_PIXELS);
   localparam int TW_W  = CIT_W + 1;
   localparam int RIT_W = $clog2(TILE_HEIGHT_ROWS);
   localparam int TH_W  = RIT_W + 1;

   localparam logic [TW_W-1:0] TW_FULL = TW_W'(TILE_WIDTH_PIXELS);
   localparam logic [TW_W-1:0] TW_HALF = TW_W'(TILE_WIDTH_PIXELS / 2);
   localparam logic [TH_W-1:0] TH_ROWS = TH_W'(TILE_HEIGHT_ROWS);
   localparam logic [Y_W-1:0]  TH_STEP = Y_W'(TILE_HEIGHT_ROWS);
   localparam logic [HEIGHT_CMP_W-1:0] TH_TWICE = HEIGHT_CMP_W'(2 * TILE_HEIGHT_ROWS);
   localparam logic [PX_SPAN_W-1:0]    PX_MAX   = PX_SPAN_W'(MAX_WIDTH_PX);
   localparam logic [9:0]              ROWS_MAX = 10'(MAX_HEIGHT);

   logic [COLOR_W-1:0] palette_ff [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rdata_ff;

   logic [X_W-1:0]   tc_ff,  tc_in;
   logic [Y_W-1:0]   tr_ff,  tr_in;
   logic [CIT_W-1:0] cit_ff, cit_in;
   logic [RIT_W-1:0] rit_ff, rit_in;
   logic             sub_ff, sub_in;
   logic             out_valid_ff, out_valid_in;
   logic [X_W-1:0]   x_ff;
   logic [Y_W-1:0]   y_ff;
   logic             last_ff;
   logic             end_ff;

   logic                  out_free;
   logic                  is_pixel;
   logic                  issue;
   logic                  do_write;
   logic                  last_pick;
   logic [PAL_ADDR_W-1:0] rd_index;
   logic [TW_W-1:0]       tile_w;
   logic [PX_SPAN_W-1:0]  px_raw;
   logic [PX_SPAN_W-1:0]  px_cap;
   logic [9:0]            h_cap;
   logic                  col_more;
   logic                  row_more;
   logic                  tc_more;
   logic                  tr_more;
   logic                  done;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign is_pixel = (q_entry.op == OP_PIXEL);
   assign issue    = q_valid && is_pixel && out_free;
   assign do_write = q_valid && !is_pixel;
   assign last_pick = !cfg.four_bit_mode || sub_ff;
   assign q_pop    = do_write || (issue && last_pick);

   // low nibble first in 4-bit mode
   always_comb begin
      if (!cfg.four_bit_mode) begin
         rd_index = q_entry.addr;
      end else if (sub_ff) begin
         rd_index = {4'b0000, q_entry.addr[7:4]};
      end else begin
         rd_index = {4'b0000, q_entry.addr[3:0]};
      end
   end

   // image extent; the width check rounds down to whole tiles
   assign tile_w = cfg.four_bit_mode ? TW_FULL : TW_HALF;
   assign px_raw = cfg.four_bit_mode ? {cfg.width_halfwords, 2'b00}
                                     : {1'b0, cfg.width_halfwords, 1'b0};
   assign px_cap = (px_raw > PX_MAX) ? PX_MAX : px_raw;
   assign h_cap  = (cfg.height_rows > ROWS_MAX) ? ROWS_MAX : cfg.height_rows;

   assign col_more = ({1'b0, cit_ff} + 1'b1) < tile_w;
   assign row_more = ({1'b0, rit_ff} + 1'b1) < TH_ROWS;
   assign tc_more  = (WIDTH_CMP_W'(tc_ff) + WIDTH_CMP_W'({tile_w, 1'b0}))
                     <= WIDTH_CMP_W'(px_cap);
   assign tr_more  = (HEIGHT_CMP_W'(tr_ff) + TH_TWICE) <= HEIGHT_CMP_W'(h_cap);

   always_comb begin
      tc_in  = tc_ff;
      tr_in  = tr_ff;
      cit_in = cit_ff;
      rit_in = rit_ff;
      done   = 1'b0;
      if (col_more) begin
         cit_in = cit_ff + 1'b1;
      end else begin
         cit_in = '0;
         if (row_more) begin
            rit_in = rit_ff + 1'b1;
         end else begin
            rit_in = '0;
            if (tc_more) begin
               tc_in = tc_ff + X_W'(tile_w);
            end else begin
               tc_in = '0;
               if (tr_more) begin
                  tr_in = tr_ff + TH_STEP;
               end else begin
                  tr_in = '0;
                  done  = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      sub_in = sub_ff;
      if (issue && cfg.four_bit_mode) begin
         sub_in = !sub_ff;
      end
      out_valid_in = out_valid_ff;
      if (issue) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         tc_ff  <= '0;
         tr_ff  <= '0;
         cit_ff <= '0;
         rit_ff <= '0;
      end else if (issue) begin
         tc_ff  <= tc_in;
         tr_ff  <= tr_in;
         cit_ff <= cit_in;
         rit_ff <= rit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // palette ram, one access per cycle
   always_ff @(posedge clock) begin
      if (do_write) begin
         palette_ff[q_entry.addr] <= q_entry.color;
      end
      if (issue) begin
         rdata_ff <= palette_ff[rd_index];
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         x_ff    <= tc_ff + X_W'(cit_ff);
         y_ff    <= tr_ff + Y_W'(rit_ff);
         last_ff <= last_pick;
         end_ff  <= done;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_data.pixel_x     = x_ff;
   assign rsp_data.pixel_y     = y_ff;
   assign rsp_data.red         = {rdata_ff[4:0], 3'b000};
   assign rsp_data.green       = {rdata_ff[9:5], 3'b000};
   assign rsp_data.blue        = {rdata_ff[14:10], 3'b000};
   assign rsp_data.alpha       = (rdata_ff == '0) ? 8'h00 : 8'hFF;
   assign rsp_data.last_of_run = last_ff;
   assign rsp_data.image_end   = end_ff;

endmodule

`default_nettype wire

// ----- src/clut_tiled_texture_decode.sv -----
// top level of the palette-indexed tiled texture decoder
// depends on ctd_pkg, ctd_front, ctd_queue, ctd_back
`default_nettype none

//  channel  direction  handshake               payload
//  req_     in         req_valid / req_stall   req_type: func, index, color, byte
//  rsp_     out        rsp_valid / rsp_stall   rsp_type: x, y, rgba, flags
//  csr_     in         csr_valid / csr_ready   csr_index, csr_wdata
//
//  8-bit mode: one byte per cycle while the output does not stall; 4-bit mode:
//  a byte stays at the queue head until the single pixel output register has
//  taken both its pixels. a palette load does not wait on the output register.
//  a pixel passes the front register, the queue and the palette read register.
//  reset is synchronous; palette ram has no reset and is undefined until loaded.
//  either side may stall at any time; the queue lets the input keep flowing
//  while a pixel waits in the output register.

module clut_tiled_texture_decode
   import ctd_pkg::*;
#(
   parameter int TILE_WIDTH_PIXELS = 128,
   parameter int TILE_HEIGHT_ROWS  = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic       four_bit_ff,   four_bit_in;
   logic [8:0] width_ff,      width_in;
   logic [9:0] height_ff,     height_in;
   logic       csr_write;
   logic       csr_hit;
   cfg_type    cfg;

   // front to queue to back
   logic      q_push;
   entry_type q_push_entry;
   logic      q_full;
   logic      q_pop;
   logic      q_valid;
   entry_type q_head;

   // writes are always taken; only known indexes restart the tile walk
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      four_bit_in = four_bit_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      csr_hit     = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FOUR_BIT_MODE: begin
               four_bit_in = csr_wdata[0];
               csr_hit     = 1'b1;
            end
            CSR_WIDTH_HALFWORDS: begin
               width_in = csr_wdata[8:0];
               csr_hit  = 1'b1;
            end
            CSR_HEIGHT_ROWS: begin
               height_in = csr_wdata;
               csr_hit   = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         four_bit_ff <= 1'b0;
         width_ff    <= WIDTH_HALFWORDS_RESET;
         height_ff   <= HEIGHT_ROWS_RESET;
      end else begin
         four_bit_ff <= four_bit_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
      end
   end

   assign cfg.four_bit_mode   = four_bit_ff;
   assign cfg.width_halfwords = width_ff;
   assign cfg.height_rows     = height_ff;
   assign cfg.restart         = csr_hit;

   // front: registers and classifies each request transfer
   ctd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_entry   (q_push_entry),
      .q_full    (q_full)
   );

   // queue: keeps palette loads and pixel bytes in order
   ctd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   // back: palette ram, tile walk, pixel output register
   ctd_back #(
      .TILE_WIDTH_PIXELS (TILE_WIDTH_PIXELS),
      .TILE_HEIGHT_ROWS  (TILE_HEIGHT_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_entry   (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// self-checking bench for clut_tiled_texture_decode: palette loads, pixel bytes, register writes
// depends on ctd_pkg and the decoder rtl; a small scoreboard class predicts every pixel
`default_nettype none

module tb_top;
   import ctd_pkg::*;

   // tile geometry the decoder is built with
   localparam int TILE_W = 128;
   localparam int TILE_H = 32;

   // index 3 is not a register; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // margin to wait once every expected pixel has arrived
   localparam int DRAIN_CYCLES = 8;

   // items per random phase and the point where the sender waits for the pipe to empty
   localparam int PHASE_ITEMS = 90;
   localparam int PHASE_PAUSE = 45;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // expected pixel stream: palette copy, tile walk position and registers
   class decode_scoreboard;
      logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
      bit                 four_bit;
      logic [8:0]         width_hw;
      logic [9:0]         height;
      logic [X_W-1:0]     tile_x;
      logic [Y_W-1:0]     tile_y;
      logic [6:0]         col;
      logic [4:0]         row;
      rsp_type            expected_pixels [$];
      int                 failures;

      function new();
         four_bit = 1'b0;
         width_hw = WIDTH_HALFWORDS_RESET;
         height   = HEIGHT_ROWS_RESET;
         failures = 0;
         restart();
      endfunction

      function void restart();
         tile_x = '0;
         tile_y = '0;
         col    = '0;
         row    = '0;
      endfunction

      function int unsigned tile_px();
         return four_bit ? TILE_W : TILE_W / 2;
      endfunction

      // width in pixels, capped and rounded down to whole tiles, at least one
      function int unsigned image_px();
         int unsigned t;
         int unsigned px;
         t  = tile_px();
         px = four_bit ? width_hw * 4 : width_hw * 2;
         if (px > MAX_WIDTH_PX) px = MAX_WIDTH_PX;
         px = px / t * t;
         if (px < t) px = t;
         return px;
      endfunction

      function int unsigned image_rows();
         int unsigned h;
         h = height;
         if (h > MAX_HEIGHT) h = MAX_HEIGHT;
         h = h / TILE_H * TILE_H;
         if (h < TILE_H) h = TILE_H;
         return h;
      endfunction

      // step the walk: across the tile, down the tile, next tile, next tile row
      function bit advance();
         if (col + 1 < tile_px()) begin
            col = col + 7'd1;
            return 1'b0;
         end
         col = '0;
         if (row + 1 < TILE_H) begin
            row = row + 5'd1;
            return 1'b0;
         end
         row = '0;
         if (tile_x + tile_px() < image_px()) begin
            tile_x = X_W'(tile_x + tile_px());
            return 1'b0;
         end
         tile_x = '0;
         if (tile_y + TILE_H < image_rows()) begin
            tile_y = Y_W'(tile_y + TILE_H);
            return 1'b0;
         end
         tile_y = '0;
         return 1'b1;
      endfunction

      function rsp_type decode(logic [7:0] idx, bit last);
         logic [COLOR_W-1:0] c;
         rsp_type            p;
         c             = palette_mem[idx];
         p.pixel_x     = tile_x + X_W'(col);
         p.pixel_y     = tile_y + Y_W'(row);
         p.red         = {c[4:0], 3'b000};
         p.green       = {c[9:5], 3'b000};
         p.blue        = {c[14:10], 3'b000};
         p.alpha       = (c == '0) ? 8'h00 : 8'hFF;
         p.last_of_run = last;
         p.image_end   = advance();
         return p;
      endfunction

      function void note_request(req_type it);
         if (it.func == OP_PALETTE_LOAD) begin
            palette_mem[it.palette_index] = it.palette_color;
            return;
         end
         if (four_bit) begin
            expected_pixels.push_back(decode({4'h0, it.pixel_byte[3:0]}, 1'b0));
            expected_pixels.push_back(decode({4'h0, it.pixel_byte[7:4]}, 1'b1));
         end else begin
            expected_pixels.push_back(decode(it.pixel_byte, 1'b1));
         end
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FOUR_BIT_MODE:   four_bit = data[0];
            CSR_WIDTH_HALFWORDS: width_hw = data[8:0];
            CSR_HEIGHT_ROWS:     height   = data;
            default:             return;
         endcase
         restart();
      endfunction

      function string describe(rsp_type p);
         return $sformatf("x=%0d y=%0d rgba=%02h%02h%02h%02h last=%0b end=%0b",
                          p.pixel_x, p.pixel_y, p.red, p.green, p.blue, p.alpha,
                          p.last_of_run, p.image_end);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("%s", msg);
      endfunction

      function void check_pixel(rsp_type got);
         rsp_type want;
         if (expected_pixels.size() == 0) begin
            note_failure({"pixel with nothing expected: ", describe(got)});
            return;
         end
         want = expected_pixels.pop_front();
         if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
             got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.alpha !== want.alpha ||
             got.last_of_run !== want.last_of_run || got.image_end !== want.image_end)
            note_failure({"pixel mismatch, expected ", describe(want), ", got ", describe(got)});
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void check_leftovers();
         if (expected_pixels.size() != 0)
            note_failure($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FOUR_BIT_MODE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   decode_scoreboard sb = new();

   // palette slots written so far; unwritten slots are never read
   bit loaded [PALETTE_DEPTH];

   // per-cycle idle chances in percent, set per phase
   int send_pct  = 0;
   int stall_pct = 0;

   // corner colours: zero, all ones, bit 15 alone, each channel alone, mixes
   logic [COLOR_W-1:0] seed_colors [16] = '{
      16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h001F, 16'h03E0, 16'h7C00, 16'h0001,
      16'h0021, 16'h0401, 16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h8001, 16'h7BDE};

   clut_tiled_texture_decode #(
      .TILE_WIDTH_PIXELS(TILE_W),
      .TILE_HEIGHT_ROWS (TILE_H)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // result side: check each transfer, then pick the next stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_pixel(rsp_data);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // one input transfer; valid stays up after it so back-to-back items need no gap
   task automatic send(req_type it);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (it.func == OP_PALETTE_LOAD) loaded[it.palette_index] = 1'b1;
      sb.note_request(it);
   endtask

   // stop sending and wait for every pixel, plus margin for a trailing load
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high so that writes can follow back to back
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // unused upper data bits get random values, the register must mask them
   task automatic program_regs(bit four, logic [8:0] w, logic [9:0] h);
      write_reg(CSR_FOUR_BIT_MODE, {9'($urandom), four});
      write_reg(CSR_WIDTH_HALFWORDS, {1'($urandom), w});
      write_reg(CSR_HEIGHT_ROWS, h);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'h8000;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   function automatic req_type load_item(logic [7:0] idx, logic [COLOR_W-1:0] color);
      req_type it;
      it.func          = OP_PALETTE_LOAD;
      it.palette_index = idx;
      it.palette_color = color;
      it.pixel_byte    = 8'($urandom);
      return it;
   endfunction

   function automatic req_type pixel_item(logic [7:0] b);
      req_type it;
      it.func          = OP_PIXEL;
      it.palette_index = 8'($urandom);
      it.palette_color = COLOR_W'($urandom);
      it.pixel_byte    = b;
      return it;
   endfunction

   // mostly pixels over loaded slots, a quarter palette loads; ignored fields random
   task automatic send_random();
      req_type it;
      it.func          = ($urandom_range(0, 99) < 25) ? OP_PALETTE_LOAD : OP_PIXEL;
      it.palette_index = 8'($urandom);
      it.palette_color = pick_color();
      it.pixel_byte    = 8'($urandom);
      // 8-bit mode reads the whole byte as a slot, keep it on a loaded one
      if (it.func == OP_PIXEL && !sb.four_bit && !loaded[it.pixel_byte])
         it.pixel_byte = 8'($urandom_range(0, 15));
      send(it);
   endtask

   initial begin
      idle_mode_type mode;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: corner colours, top and middle slots, then bytes under reset settings
      for (int i = 0; i < 16; i++) send(load_item(8'(i), seed_colors[i]));
      send(load_item(8'hFF, 16'h7C1F));
      send(load_item(8'h80, 16'h03FF));
      send(pixel_item(8'h00));
      send(pixel_item(8'hFF));
      send(pixel_item(8'h80));
      send(pixel_item(8'h02));
      // 4-bit mode: low nibble first, two pixels per byte
      drain();
      write_reg(CSR_FOUR_BIT_MODE, {9'd0, 1'b1});
      csr_valid <= 1'b0;
      send(pixel_item(8'h10));
      send(pixel_item(8'hF3));

      // random phases, each with its own register setting and idle pattern
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         case (ph)
            0: program_regs(1'b1, 9'd32, 10'd32);
            1: program_regs(1'b0, 9'd256, 10'd512);
            2: program_regs(1'b1, 9'd511, 10'd1023);
            3: program_regs(1'b0, 9'd0, 10'd0);
            // write to a non-register index: the walk must carry on from where it was
            4: begin
               write_reg(CSR_UNUSED, CSR_DATA_W'($urandom));
               csr_valid <= 1'b0;
            end
            default: program_regs(1'($urandom), 9'($urandom_range(32, 256)),
                                  10'($urandom_range(32, 512)));
         endcase
         mode = idle_mode_type'(ph % 4);
         send_pct  = (mode == IDLE_SENDER)   ? 86 : (mode == IDLE_BOTH) ? 28 : 0;
         stall_pct = (mode == IDLE_RECEIVER) ? 86 : (mode == IDLE_BOTH) ? 28 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // halfway through, hold off until the pipe is empty
            if (n == PHASE_PAUSE) drain();
            send_random();
         end
      end

      // fresh settings, new colours in the low slots, then a gap-free burst of bytes
      drain();
      send_pct  = 0;
      stall_pct = 0;
      program_regs(1'b0, 9'd64, 10'd64);
      for (int i = 0; i < 16; i++) send(load_item(8'(i), pick_color()));
      for (int i = 0; i < 40; i++) send(pixel_item(8'($urandom_range(0, 15))));

      drain();
      sb.check_leftovers();
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
